>>> hdl/tcst_pkg.sv
`default_nettype none
package tcst_pkg;
  localparam int SlotsDefault = 8;
  localparam int MaxResults = 8;
  localparam logic [31:0] IsnDefault = 32'd42;
  localparam logic [7:0] RtoDefault = 8'd4;

  localparam logic [1:0] FUNC_RX = 2'd0;
  localparam logic [1:0] FUNC_TX = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;
  localparam logic [1:0] FUNC_OPEN = 2'd3;

  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_SYN = 3'd1;
  localparam logic [2:0] KIND_SYNACK = 3'd2;
  localparam logic [2:0] KIND_ACK = 3'd3;
  localparam logic [2:0] KIND_ACKFIN = 3'd4;
  localparam logic [2:0] KIND_DATA = 3'd5;
  localparam logic [2:0] KIND_RETX = 3'd6;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_EXISTS = 2'd2;
  localparam logic [1:0] ST_DROP = 2'd3;

  localparam logic [2:0] CS_NONE = 3'd0;
  localparam logic [2:0] CS_HS = 3'd1;
  localparam logic [2:0] CS_EST = 3'd2;
  localparam logic [2:0] CS_RESET = 3'd3;
  localparam logic [2:0] CS_CLOSED = 3'd4;

  localparam logic [1:0] REG_LISTEN = 2'd0;
  localparam logic [1:0] REG_ISN = 2'd1;
  localparam logic [1:0] REG_RTO = 2'd2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [15:0] len;
    logic [2:0]  slot;
    logic        deliver;
  } res_t;

  function automatic logic seq_le(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    begin
      d = b - a;
      seq_le = !d[31];
    end
  endfunction
endpackage
`default_nettype wire

>>> hdl/tcp_connection_seq_ack_tracker.sv
`default_nettype none
// One TCP connection tracker. Each input beat holds in_tready low until its last result
// beat is taken. An item is decoded, its first result beat is loaded, the remaining
// beats follow as each is taken, and the tracker returns to idle before the next input
// beat is taken. A received segment that reaches the send ring retires up to SLOTS
// slots: each is read through the single ring read port and registered before the ack
// compare can test it. A timer tick on an open connection visits up to SLOTS slots, one
// slot per cycle through the same read port, with its own timeout compare. Results
// leave through a one-deep output register.
module tcp_connection_seq_ack_tracker #(
  parameter int SLOTS = tcst_pkg::SlotsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // tdata: func[1:0], flag_syn, flag_ack, flag_fin, flag_rst, seg_seq, seg_ack,
  //        length, consumer_ready, time_now, zero pad (120 bits)
  input  wire logic [119:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tdata: out_kind, out_seq, out_ack, out_length, out_slot, deliver, status,
  //        conn_state, zero pad (96 bits)
  output logic [95:0]      out_tdata,
  output logic             out_tlast,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam int PW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DEC  = 6'b000010,
    S_ACKW = 6'b000100,
    S_TICK = 6'b001000,
    S_RES  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  logic        listen_en;
  logic [31:0] isn;
  logic [7:0]  rto_mul;
  logic [39:0] rto;

  assign cfg_pready = 1'b1;

  tcst_cfg u_cfg (
    .clk, .rst_n, .psel(cfg_psel), .penable(cfg_penable), .pwrite(cfg_pwrite),
    .paddr(cfg_paddr), .pwdata(cfg_pwdata), .prdata(cfg_prdata),
    .listen_en, .isn, .rto_mul
  );

  state_t st_r;
  logic [119:0] in_r;
  logic [1:0]  func;
  logic syn, ack, fin, rst_f, ready;
  logic [31:0] sseq, sack, now;
  logic [15:0] len;
  assign func = in_r[1:0];
  assign syn = in_r[2];
  assign ack = in_r[3];
  assign fin = in_r[4];
  assign rst_f = in_r[5];
  assign sseq = in_r[37:6];
  assign sack = in_r[69:38];
  assign len = in_r[85:70];
  assign ready = in_r[86];
  assign now = in_r[118:87];

  logic conn_r, hs_r, wrst_r, wcl_r;
  logic [31:0] nss_r, rexp_r, rt_r;
  logic [PW-1:0] fill_r, old_r, scan_r;
  logic [CW-1:0] cnt_r;
  logic [SLOTS-1:0] used_r;
  logic [31:0] m_eack [SLOTS];
  logic [31:0] m_seq [SLOTS];
  logic [15:0] m_len [SLOTS];
  logic [31:0] m_time [SLOTS];
  logic [31:0] rd_eack, rd_seq, rd_time;
  logic [15:0] rd_len;
  logic [PW-1:0] rd_addr;
  logic rd_vld_r;
  logic [PW-1:0] rd_slot_r;
  logic wr_en;
  logic [PW-1:0] wr_addr;
  logic [31:0] wr_eack, wr_seq, wr_time;
  logic [15:0] wr_len;
  logic wr_full;

  tcst_mul u_mul (.clk, .a(rt_r), .b(rto_mul), .p(rto));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      m_time[wr_addr] <= wr_time;
      if (wr_full) begin
        m_eack[wr_addr] <= wr_eack;
        m_seq[wr_addr] <= wr_seq;
        m_len[wr_addr] <= wr_len;
      end
    end
    rd_eack <= m_eack[rd_addr];
    rd_seq <= m_seq[rd_addr];
    rd_len <= m_len[rd_addr];
    rd_time <= m_time[rd_addr];
  end

  tcst_pkg::res_t rq_r [tcst_pkg::MaxResults];
  logic [3:0] nres_r, oidx_r;
  logic [1:0] status_r;
  logic [2:0] cs;
  logic [PW-1:0] slot_nx;

  always_comb begin
    if (!conn_r) cs = wcl_r ? tcst_pkg::CS_CLOSED : tcst_pkg::CS_NONE;
    else if (wrst_r) cs = tcst_pkg::CS_RESET;
    else cs = hs_r ? tcst_pkg::CS_HS : tcst_pkg::CS_EST;
  end

  assign in_tready = rst_n && (st_r == S_IDLE);
  assign rd_addr = scan_r;
  assign slot_nx = (scan_r == PW'(SLOTS - 1)) ? '0 : scan_r + 1'b1;

  logic [40:0] tsum;
  assign tsum = {9'd0, rd_time} + {1'b0, rto};

  always_comb begin
    wr_en = 1'b0;
    wr_full = 1'b0;
    wr_addr = fill_r;
    wr_eack = nss_r + {16'd0, len};
    wr_seq = nss_r;
    wr_len = len;
    wr_time = now;
    if (st_r == S_DEC && func == tcst_pkg::FUNC_TX && conn_r && len != 16'd0 &&
        !used_r[fill_r]) begin
      wr_en = 1'b1;
      wr_full = 1'b1;
    end
    if (st_r == S_TICK && rd_vld_r && used_r[rd_slot_r] && nres_r < 4'd8 &&
        tsum < {9'd0, now}) begin
      wr_en = 1'b1;
      wr_addr = rd_slot_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      conn_r <= 1'b0; hs_r <= 1'b0; wrst_r <= 1'b0; wcl_r <= 1'b0;
      nss_r <= '0; rexp_r <= '0; rt_r <= '0;
      fill_r <= '0; old_r <= '0; scan_r <= '0; cnt_r <= '0;
      used_r <= '0; nres_r <= '0; oidx_r <= '0; status_r <= '0;
      rd_vld_r <= 1'b0; rd_slot_r <= '0;
      out_tvalid <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (in_tvalid) begin
            in_r <= in_tdata;
            st_r <= S_DEC;
          end
        end
        S_DEC: begin
          nres_r <= '0;
          status_r <= tcst_pkg::ST_OK;
          scan_r <= old_r;
          cnt_r <= '0;
          rd_vld_r <= 1'b0;
          st_r <= S_OUT;
          oidx_r <= '0;
          case (func)
            tcst_pkg::FUNC_RX: begin
              if (syn) begin
                if (ack) begin
                  if (!conn_r) status_r <= tcst_pkg::ST_DROP;
                  else begin
                    if (hs_r) rt_r <= now - rt_r;
                    hs_r <= 1'b0;
                    rexp_r <= sseq + 1'b1;
                    rq_r[0] <= '{tcst_pkg::KIND_ACK, nss_r, sseq + 1'b1, 16'd0, 3'd0, 1'b0};
                    nres_r <= 4'd1;
                  end
                end else if (!listen_en) status_r <= tcst_pkg::ST_DROP;
                else if (conn_r) status_r <= tcst_pkg::ST_EXISTS;
                else begin
                  conn_r <= 1'b1; hs_r <= 1'b1; wrst_r <= 1'b0; wcl_r <= 1'b0;
                  rexp_r <= sseq + 1'b1; fill_r <= '0; old_r <= '0; used_r <= '0;
                  rt_r <= now;
                  nss_r <= isn + 1'b1;
                  rq_r[0] <= '{tcst_pkg::KIND_SYNACK, isn, sseq + 1'b1, 16'd0, 3'd0, 1'b0};
                  nres_r <= 4'd1;
                end
              end else if (!conn_r) status_r <= tcst_pkg::ST_DROP;
              else if (fin && ack) begin
                if (nss_r != sack || rexp_r != sseq) status_r <= tcst_pkg::ST_DROP;
                else begin
                  rexp_r <= rexp_r + 1'b1;
                  wcl_r <= 1'b1; conn_r <= 1'b0;
                  rq_r[0] <= '{tcst_pkg::KIND_ACKFIN, nss_r, rexp_r + 1'b1, 16'd0, 3'd0,
                              1'b0};
                  nres_r <= 4'd1;
                end
              end else if (rst_f) begin
                hs_r <= 1'b0; wrst_r <= 1'b1;
              end else begin
                if (hs_r) begin
                  rt_r <= now - rt_r;
                  hs_r <= 1'b0;
                end
                st_r <= S_ACKW;
              end
            end
            tcst_pkg::FUNC_TX: begin
              if (!conn_r) status_r <= tcst_pkg::ST_DROP;
              else if (len == 16'd0) status_r <= tcst_pkg::ST_OK;
              else if (used_r[fill_r]) status_r <= tcst_pkg::ST_FULL;
              else begin
                rq_r[0] <= '{tcst_pkg::KIND_DATA, nss_r, rexp_r, len, 3'(fill_r), 1'b0};
                nres_r <= 4'd1;
                nss_r <= nss_r + {16'd0, len};
                used_r[fill_r] <= 1'b1;
                fill_r <= (fill_r == PW'(SLOTS - 1)) ? '0 : fill_r + 1'b1;
              end
            end
            tcst_pkg::FUNC_TICK: begin
              if (conn_r) st_r <= S_TICK;
            end
            default: begin
              if (conn_r) status_r <= tcst_pkg::ST_EXISTS;
              else begin
                conn_r <= 1'b1; hs_r <= 1'b1; wrst_r <= 1'b0; wcl_r <= 1'b0;
                rexp_r <= '0; fill_r <= '0; old_r <= '0; used_r <= '0;
                rt_r <= now;
                nss_r <= isn + 1'b1;
                rq_r[0] <= '{tcst_pkg::KIND_SYN, isn, 32'd0, 16'd0, 3'd0, 1'b0};
                nres_r <= 4'd1;
              end
            end
          endcase
        end
        S_ACKW: begin
          rd_vld_r <= 1'b1;
          rd_slot_r <= scan_r;
          if (rd_vld_r) begin
            if (cnt_r != CW'(SLOTS) && used_r[rd_slot_r] &&
                tcst_pkg::seq_le(rd_eack, sack)) begin
              used_r[rd_slot_r] <= 1'b0;
              old_r <= (rd_slot_r == PW'(SLOTS - 1)) ? '0 : rd_slot_r + 1'b1;
              cnt_r <= cnt_r + 1'b1;
              scan_r <= slot_nx;
              rd_vld_r <= 1'b0;
            end else begin
              st_r <= S_RES;
            end
          end
        end
        S_RES: begin
          st_r <= S_OUT;
          if (len != 16'd0) begin
            if (rexp_r == sseq) begin
              if (!ready) status_r <= tcst_pkg::ST_DROP;
              else begin
                rexp_r <= sseq + {16'd0, len};
                rq_r[0] <= '{tcst_pkg::KIND_ACK, nss_r, sseq + {16'd0, len}, 16'd0, 3'd0,
                            1'b1};
                nres_r <= 4'd1;
              end
            end else if (!tcst_pkg::seq_le(rexp_r, sseq)) begin
              rq_r[0] <= '{tcst_pkg::KIND_ACK, nss_r, rexp_r, 16'd0, 3'd0, 1'b0};
              nres_r <= 4'd1;
            end else status_r <= tcst_pkg::ST_DROP;
          end
        end
        S_TICK: begin
          // memory read is registered, so it trails scan_r; rd_slot_r names the slot it holds
          rd_vld_r <= 1'b1;
          rd_slot_r <= scan_r;
          scan_r <= slot_nx;
          if (rd_vld_r) begin
            if (cnt_r == CW'(SLOTS) || !used_r[rd_slot_r] || nres_r == 4'd8) begin
              st_r <= S_OUT;
            end else begin
              cnt_r <= cnt_r + 1'b1;
              if (tsum < {9'd0, now}) begin
                rq_r[nres_r[2:0]] <= '{tcst_pkg::KIND_RETX, rd_seq, rexp_r, rd_len,
                                      3'(rd_slot_r), 1'b0};
                nres_r <= nres_r + 1'b1;
              end
            end
          end
        end
        S_OUT: begin
          if (!out_tvalid || out_tready) begin
            if (out_tvalid && out_tlast) begin
              out_tvalid <= 1'b0;
              st_r <= S_IDLE;
            end else begin
              out_tvalid <= 1'b1;
              oidx_r <= oidx_r + 1'b1;
              if (nres_r == 4'd0) begin
                out_tdata <= {4'd0, cs, status_r, 1'b0, 3'd0, 16'd0, 32'd0, 32'd0,
                              tcst_pkg::KIND_NONE};
                out_tlast <= 1'b1;
              end else begin
                out_tdata <= {4'd0, cs, status_r, rq_r[oidx_r[2:0]].deliver,
                              rq_r[oidx_r[2:0]].slot, rq_r[oidx_r[2:0]].len,
                              rq_r[oidx_r[2:0]].ack, rq_r[oidx_r[2:0]].seq,
                              rq_r[oidx_r[2:0]].kind};
                out_tlast <= (oidx_r + 1'b1 == nres_r);
              end
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> hdl/tcst_cfg.sv
`default_nettype none
module tcst_cfg (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             listen_en,
  output logic [31:0]      isn,
  output logic [7:0]       rto_mul
);
  logic        listen_r;
  logic [31:0] isn_r;
  logic [7:0]  rto_r;
  logic [1:0]  idx;

  assign idx = paddr[3:2];
  assign listen_en = listen_r;
  assign isn = isn_r;
  assign rto_mul = rto_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      listen_r <= 1'b0;
      isn_r <= tcst_pkg::IsnDefault;
      rto_r <= tcst_pkg::RtoDefault;
    end else if (psel && penable && pwrite) begin
      case (idx)
        tcst_pkg::REG_LISTEN: listen_r <= pwdata[0];
        tcst_pkg::REG_ISN: isn_r <= pwdata;
        tcst_pkg::REG_RTO: rto_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      tcst_pkg::REG_LISTEN: prdata = {31'd0, listen_r};
      tcst_pkg::REG_ISN: prdata = isn_r;
      tcst_pkg::REG_RTO: prdata = {24'd0, rto_r};
      default: prdata = 32'd0;
    endcase
  end
endmodule
`default_nettype wire

>>> hdl/tcst_mul.sv
`default_nettype none
// 32x8 multiply into a register
module tcst_mul (
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [7:0]  b,
  output logic [39:0]      p
);
  logic [39:0] p_r;
  assign p = p_r;
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end
endmodule
`default_nettype wire

>>> sim/tcp_seq_ack_checker.sv
module tcp_seq_ack_checker (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [119:0] in_tdata,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [95:0]  out_tdata,
  input  wire logic         out_tlast,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [3:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  input  wire logic         cfg_pready,
  output int                errors,
  output int                pending
);
  typedef struct {
    logic [2:0]  kind;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [15:0] len;
    logic [2:0]  slot;
    logic        dlv;
    logic [1:0]  status;
    logic [2:0]  cs;
    logic        last;
  } seg_out_t;

  seg_out_t segs_due[$];
  seg_out_t burst[$];

  logic        listen_en;
  logic [31:0] isn;
  logic [7:0]  rto_mult;

  logic        open_q, hs_q, rst_seen, fin_seen;
  logic [31:0] snd_nxt, snd_last, rcv_nxt, ack_hi, rtt;
  logic [2:0]  fill_idx, old_idx;
  logic        ring_used[8];
  logic [31:0] ring_end[8];
  logic [31:0] ring_seq[8];
  logic [15:0] ring_len[8];
  logic [31:0] ring_time[8];

  function automatic logic wrap_le(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = b - a;
    return !d[31];
  endfunction

  task automatic add_seg(input logic [2:0] kind, input logic [31:0] seq,
                         input logic [31:0] ack, input logic [15:0] len,
                         input logic [2:0] slot, input logic dlv);
    seg_out_t s;
    if (burst.size() < tcst_pkg::MaxResults) begin
      s = '{kind, seq, ack, len, slot, dlv, tcst_pkg::ST_OK, tcst_pkg::CS_NONE, 1'b0};
      burst.push_back(s);
    end
  endtask

  task automatic add_ctl(input logic [2:0] kind, input logic dlv);
    snd_last = snd_nxt;
    add_seg(kind, snd_nxt, rcv_nxt, 16'd0, 3'd0, dlv);
  endtask

  task automatic start_conn(input logic [31:0] ack, input logic [31:0] now);
    open_q = 1; hs_q = 1; rst_seen = 0; fin_seen = 0;
    snd_nxt = isn; snd_last = isn; rcv_nxt = ack; ack_hi = 0;
    fill_idx = 0; old_idx = 0;
    for (int i = 0; i < 8; i++) ring_used[i] = 0;
    rtt = now;
  endtask

  task automatic take_segment(input logic [119:0] d, output logic [1:0] st);
    logic syn, ack, fin, rst, rdy;
    logic [31:0] sseq, sack, now;
    logic [15:0] len;
    logic [2:0] p;
    syn = d[2]; ack = d[3]; fin = d[4]; rst = d[5];
    sseq = d[37:6]; sack = d[69:38]; len = d[85:70]; rdy = d[86]; now = d[118:87];
    st = tcst_pkg::ST_OK;
    if (syn) begin
      if (ack) begin
        if (!open_q) begin st = tcst_pkg::ST_DROP; return; end
        if (hs_q) rtt = now - rtt;
        hs_q = 0; ack_hi = sack; rcv_nxt = sseq + 1;
        add_ctl(tcst_pkg::KIND_ACK, 0);
        return;
      end
      if (!listen_en) begin st = tcst_pkg::ST_DROP; return; end
      if (open_q) begin st = tcst_pkg::ST_EXISTS; return; end
      start_conn(sseq + 1, now);
      add_ctl(tcst_pkg::KIND_SYNACK, 0);
      snd_nxt = snd_nxt + 1;
      return;
    end
    if (!open_q) begin st = tcst_pkg::ST_DROP; return; end
    if (fin && ack) begin
      if (snd_nxt != sack || rcv_nxt != sseq) begin st = tcst_pkg::ST_DROP; return; end
      rcv_nxt = rcv_nxt + 1; fin_seen = 1; open_q = 0;
      add_ctl(tcst_pkg::KIND_ACKFIN, 0);
      return;
    end
    if (rst) begin hs_q = 0; rst_seen = 1; return; end
    if (hs_q) begin rtt = now - rtt; hs_q = 0; end
    ack_hi = sack;
    for (int k = 0; k < 8; k++) begin
      p = old_idx;
      if (!ring_used[p] || !wrap_le(ring_end[p], sack)) break;
      ring_used[p] = 0;
      old_idx = p + 1;
    end
    if (len == 0) return;
    if (rcv_nxt == sseq) begin
      if (!rdy) begin st = tcst_pkg::ST_DROP; return; end
      rcv_nxt = sseq + len;
      add_ctl(tcst_pkg::KIND_ACK, 1);
      return;
    end
    if (!wrap_le(rcv_nxt, sseq)) begin add_ctl(tcst_pkg::KIND_ACK, 0); return; end
    st = tcst_pkg::ST_DROP;
  endtask

  task automatic take_send(input logic [119:0] d, output logic [1:0] st);
    logic [15:0] len;
    logic [2:0] p;
    len = d[85:70]; p = fill_idx;
    st = tcst_pkg::ST_OK;
    if (!open_q) begin st = tcst_pkg::ST_DROP; return; end
    if (len == 0) return;
    if (ring_used[p]) begin st = tcst_pkg::ST_FULL; return; end
    add_seg(tcst_pkg::KIND_DATA, snd_nxt, rcv_nxt, len, p, 0);
    snd_last = snd_nxt;
    ring_seq[p] = snd_nxt;
    snd_nxt = snd_nxt + len;
    ring_used[p] = 1; ring_len[p] = len; ring_end[p] = snd_nxt;
    ring_time[p] = d[118:87];
    fill_idx = p + 1;
  endtask

  task automatic take_tick(input logic [119:0] d);
    logic [63:0] now, rto;
    logic [2:0] p;
    now = {32'd0, d[118:87]};
    rto = {32'd0, rtt} * {56'd0, rto_mult};
    p = old_idx;
    if (!open_q) return;
    for (int k = 0; k < 8 && ring_used[p] && burst.size() < tcst_pkg::MaxResults;
         k++) begin
      if ({32'd0, ring_time[p]} + rto < now) begin
        ring_time[p] = now[31:0];
        add_seg(tcst_pkg::KIND_RETX, ring_seq[p], rcv_nxt, ring_len[p], p, 0);
      end
      p = p + 1;
    end
  endtask

  task automatic predict_beat(input logic [119:0] d);
    logic [1:0] st;
    logic [2:0] cs;
    seg_out_t s;
    burst.delete();
    st = tcst_pkg::ST_OK;
    case (d[1:0])
      tcst_pkg::FUNC_RX: take_segment(d, st);
      tcst_pkg::FUNC_TX: take_send(d, st);
      tcst_pkg::FUNC_TICK: take_tick(d);
      default: begin
        if (open_q) begin
          st = tcst_pkg::ST_EXISTS;
        end else begin
          start_conn(32'd0, d[118:87]);
          add_seg(tcst_pkg::KIND_SYN, isn, 32'd0, 16'd0, 3'd0, 0);
          snd_last = isn;
          snd_nxt = isn + 1;
        end
      end
    endcase
    if (burst.size() == 0) add_seg(tcst_pkg::KIND_NONE, 0, 0, 0, 0, 0);
    if (!open_q) cs = fin_seen ? tcst_pkg::CS_CLOSED : tcst_pkg::CS_NONE;
    else if (rst_seen) cs = tcst_pkg::CS_RESET;
    else cs = hs_q ? tcst_pkg::CS_HS : tcst_pkg::CS_EST;
    foreach (burst[i]) begin
      s = burst[i];
      s.status = st; s.cs = cs; s.last = (i == burst.size() - 1);
      segs_due.push_back(s);
    end
  endtask

  task automatic cmp_field(input string name, input logic [31:0] e, input logic [31:0] a,
                           inout logic bad);
    if (e !== a) begin
      $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, e, a);
      bad = 1;
    end
  endtask

  task automatic check_beat();
    seg_out_t e;
    logic bad;
    bad = 0;
    if (segs_due.size() == 0) begin
      $display("%0t: unexpected result beat: expected none actual %h", $time, out_tdata);
      errors++;
      return;
    end
    e = segs_due.pop_front();
    cmp_field("kind", e.kind, out_tdata[2:0], bad);
    cmp_field("seq", e.seq, out_tdata[34:3], bad);
    cmp_field("ack", e.ack, out_tdata[66:35], bad);
    cmp_field("length", e.len, out_tdata[82:67], bad);
    cmp_field("slot", e.slot, out_tdata[85:83], bad);
    cmp_field("deliver", e.dlv, out_tdata[86], bad);
    cmp_field("status", e.status, out_tdata[88:87], bad);
    cmp_field("conn_state", e.cs, out_tdata[91:89], bad);
    cmp_field("last", e.last, out_tlast, bad);
    if (bad) errors++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      listen_en = 0; isn = tcst_pkg::IsnDefault; rto_mult = tcst_pkg::RtoDefault;
      open_q = 0; hs_q = 0; rst_seen = 0; fin_seen = 0;
      snd_nxt = 0; snd_last = 0; rcv_nxt = 0; ack_hi = 0; rtt = 0;
      fill_idx = 0; old_idx = 0;
      for (int i = 0; i < 8; i++) ring_used[i] = 0;
      segs_due.delete();
      errors = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          tcst_pkg::REG_LISTEN: listen_en = cfg_pwdata[0];
          tcst_pkg::REG_ISN: isn = cfg_pwdata;
          tcst_pkg::REG_RTO: rto_mult = cfg_pwdata[7:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_beat(in_tdata);
      if (out_tvalid && out_tready) check_beat();
    end
    pending = segs_due.size();
  end
endmodule

>>> sim/tb_tcp_connection_seq_ack_tracker.sv
module tb_tcp_connection_seq_ack_tracker;
  localparam int Limit = 800000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [119:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [95:0]  out_tdata;
  logic         out_tlast;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [3:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;
  int           errors;
  int           pending;

  tcp_connection_seq_ack_tracker DUT (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .out_tlast, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_prdata, .cfg_pready
  );

  tcp_seq_ack_checker u_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .out_tlast, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_pready, .errors, .pending
  );

  bit          calm;
  bit          long_hold;
  int          cycles;
  int          sent;
  logic [31:0] now, snd, rcv, isn_sh;
  int          in_flight;
  bit          listen_sh;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver stalls
  initial begin
    out_tready = 0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_tready <= 0;
        repeat (300) @(posedge clk);
        long_hold = 0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_tready <= 1;
    end
  end

  task automatic put(input logic [1:0] f, input logic syn, input logic ack,
                     input logic fin, input logic rst, input logic [31:0] sseq,
                     input logic [31:0] sack, input logic [15:0] len, input logic rdy);
    logic ok;
    logic [31:0] t;
    now = now + $urandom_range(0, 40);
    t = ($urandom_range(0, 40) == 0) ? $urandom : now;
    in_tdata <= {1'b0, t, rdy, len, sack, sseq, rst, fin, ack, syn, f};
    in_tvalid <= 1;
    do begin
      @(negedge clk);
      ok = in_tready;
      @(posedge clk);
    end while (!ok);
    sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic put_rand(input logic [1:0] f);
    put(f, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), $urandom, $urandom,
        16'($urandom), 1'($urandom));
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    cfg_psel <= 1;
    cfg_pwrite <= 1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    cfg_penable <= 0;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    @(posedge clk);
  endtask

  task automatic configure(input logic le, input logic [31:0] isn, input logic [7:0] rto);
    cfg_write(tcst_pkg::REG_LISTEN, {31'd0, le});
    cfg_write(tcst_pkg::REG_ISN, isn);
    cfg_write(tcst_pkg::REG_RTO, {24'd0, rto});
    listen_sh = le;
    isn_sh = isn;
  endtask

  task automatic tx(input logic [15:0] len);
    put(tcst_pkg::FUNC_TX, 0, 0, 0, 0, $urandom, $urandom, len, 1'($urandom));
    if (len != 0 && in_flight < 8) begin
      snd = snd + len;
      in_flight++;
    end
  endtask

  task automatic rx_ack_all(input logic [15:0] len, input logic rdy);
    put(tcst_pkg::FUNC_RX, 0, 1, 0, 0, rcv, snd, len, rdy);
    in_flight = 0;
    if (rdy) rcv = rcv + len;
  endtask

  task automatic open_conn();
    logic [31:0] peer;
    peer = $urandom;
    if (listen_sh && $urandom_range(0, 2) == 0) begin
      put(tcst_pkg::FUNC_RX, 1, 0, 0, 0, peer, $urandom, 0, 1);
      snd = isn_sh + 1;
      rcv = peer + 1;
      put(tcst_pkg::FUNC_RX, 0, 1, 0, 0, rcv, snd, 0, 1);
    end else begin
      put_rand(tcst_pkg::FUNC_OPEN);
      snd = isn_sh + 1;
      put(tcst_pkg::FUNC_RX, 1, 1, 0, 0, peer, snd, 0, 1);
      rcv = peer + 1;
    end
    in_flight = 0;
  endtask

  task automatic episode();
    int n;
    logic [15:0] len;
    open_conn();
    n = $urandom_range(8, 40);
    repeat (n) begin
      len = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1500));
      case ($urandom_range(0, 11))
        0, 1, 2: tx(len);
        3, 4: rx_ack_all(len, $urandom_range(0, 5) != 0);
        5: put(tcst_pkg::FUNC_RX, 0, 1, 0, 0, rcv, snd - $urandom_range(1, 3000), 0, 1);
        6, 7: put_rand(tcst_pkg::FUNC_TICK);
        8: put(tcst_pkg::FUNC_RX, 0, 1, 0, 0, rcv - $urandom_range(1, 5000), snd,
               16'($urandom_range(1, 500)), 1);
        9: put(tcst_pkg::FUNC_RX, 0, 1, 0, 0, rcv + $urandom_range(1, 5000), snd,
               16'($urandom_range(1, 500)), 1);
        10: put_rand(2'($urandom));
        default: begin
          if ($urandom_range(0, 5) == 0) put(tcst_pkg::FUNC_RX, 0, 0, 0, 1, rcv, snd, 0, 1);
          else put(tcst_pkg::FUNC_OPEN, 0, 0, 0, 0, 0, 0, 0, 0);
        end
      endcase
    end
    if ($urandom_range(0, 4) == 0) put(tcst_pkg::FUNC_RX, 0, 1, 1, 0, rcv + 1, snd, 0, 1);
    put(tcst_pkg::FUNC_RX, 0, 1, 1, 0, rcv, snd, 0, 1);
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    calm = 0;
    long_hold = 0;
    cycles = 0;
    sent = 0;
    now = 0;
    snd = 0;
    rcv = 0;
    in_flight = 0;
    listen_sh = 0;
    isn_sh = tcst_pkg::IsnDefault;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: no connection, refused open, then a full active connection
    put(tcst_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
    put(tcst_pkg::FUNC_TX, 0, 0, 0, 0, 0, 0, 16'hffff, 1);
    put(tcst_pkg::FUNC_RX, 0, 1, 0, 0, 32'hffffffff, 32'hffffffff, 16'hffff, 1);
    put(tcst_pkg::FUNC_RX, 1, 0, 0, 0, 32'h1234, 0, 0, 1);
    put(tcst_pkg::FUNC_OPEN, 1, 1, 1, 1, 32'hffffffff, 32'hffffffff, 16'hffff, 1);
    snd = isn_sh + 1;
    put(tcst_pkg::FUNC_OPEN, 0, 0, 0, 0, 0, 0, 0, 0);
    put(tcst_pkg::FUNC_RX, 1, 1, 0, 0, 32'hfffffff0, snd, 0, 1);
    rcv = 32'hfffffff1;
    put(tcst_pkg::FUNC_RX, 1, 1, 0, 0, 32'hfffffff0, snd, 0, 1);
    tx(0);
    tx(16'hffff);
    tx(100);
    now = now + 5000;
    put(tcst_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
    put(tcst_pkg::FUNC_RX, 0, 1, 0, 0, rcv, snd - 100, 64, 0);
    rx_ack_all(64, 1);
    put(tcst_pkg::FUNC_RX, 0, 1, 0, 0, rcv + 10, snd, 8, 1);
    put(tcst_pkg::FUNC_RX, 0, 1, 0, 0, rcv - 10, snd, 8, 1);
    repeat (9) tx(10);
    put(tcst_pkg::FUNC_RX, 0, 0, 0, 1, rcv, snd, 0, 1);
    put(tcst_pkg::FUNC_RX, 0, 1, 1, 0, rcv, snd + 1, 0, 1);
    put(tcst_pkg::FUNC_RX, 0, 1, 1, 0, rcv, snd, 0, 1);
    drain();

    configure(1, 32'hffffffff, 8'd1);
    while (sent < 150) episode();
    long_hold = 1;
    episode();
    drain();
    configure(1, 32'h0, 8'd255);
    while (sent < 270) episode();
    drain();
    configure(0, $urandom, 8'($urandom_range(1, 255)));
    while (sent < 370) episode();
    drain();
    configure(1, tcst_pkg::IsnDefault, tcst_pkg::RtoDefault);
    while (sent < 410) episode();
    calm = 1;
    while (sent < 460) episode();

    drain();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
